>>> rtl/led_color_grading_unit_macros.svh
// Assertion macros shared by the color grading RTL
`ifndef LED_COLOR_GRADING_UNIT_MACROS_SVH
`define LED_COLOR_GRADING_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define LCG_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LCG_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lcg_pkg.sv
// Types, constants and helpers for the LED color grading unit
package lcg_pkg;

  localparam int NUM_STAGES = 3;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [7:0] CHAN_MAX        = 8'd255;
  localparam logic [7:0] LIMIT_RESET     = 8'd255;
  localparam logic [9:0] DIV3_RECIP      = 10'd683;
  localparam int         DIV3_SHIFT      = 11;

  typedef enum logic [2:0] {
    REG_COLOR_CTRL_EN = 3'd0,
    REG_COMPRESS_EN   = 3'd1,
    REG_RED_OFFSET    = 3'd2,
    REG_GREEN_OFFSET  = 3'd3,
    REG_BLUE_OFFSET   = 3'd4,
    REG_LUMA_THRESH   = 3'd5,
    REG_LUMA_LIMIT    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pixel_out_t;

  typedef struct packed {
    logic              color_control_enable;
    logic              compression_enable;
    logic signed [8:0] red_offset;
    logic signed [8:0] green_offset;
    logic signed [8:0] blue_offset;
    logic [7:0]        luma_threshold;
    logic [7:0]        luma_limit;
  } cfg_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] stage_valid;
  } pipe_status_t;

  function automatic logic [7:0] add_clamp(input logic [7:0] chan,
                                           input logic signed [8:0] offset);
    logic signed [10:0] sum;
    sum = $signed({3'b000, chan}) + 11'(offset);
    if (sum < 0) begin
      return 8'd0;
    end else if (sum > $signed({3'b000, CHAN_MAX})) begin
      return CHAN_MAX;
    end
    return sum[7:0];
  endfunction

  function automatic logic [7:0] sub_floor(input logic [7:0] chan,
                                           input logic [7:0] excess);
    if (chan > excess) begin
      return chan - excess;
    end
    return 8'd0;
  endfunction

endpackage

>>> rtl/lcg_grade_pipe.sv
// Three-stage grading datapath: offset clamp, luma, blank and limit
module lcg_grade_pipe (
  input  logic                  clk,
  input  logic                  rst,
  input  lcg_pkg::cfg_t         cfg,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  lcg_pkg::pixel_in_t    pixel,
  output logic                  graded_valid,
  input  logic                  graded_ready,
  output lcg_pkg::pixel_out_t   graded,
  output lcg_pkg::pipe_status_t status
);

  logic adv0, adv1, adv2;
  logic v0, v1, v2;

  logic [7:0] r0, g0, b0;
  logic [7:0] r1, g1, b1;
  logic [7:0] luma1;

  logic [9:0]  sum_plus;
  logic [19:0] prod;
  logic        blank;
  logic        over;
  logic [7:0]  excess;
  logic [7:0]  r_blk, g_blk, b_blk;
  lcg_pkg::pixel_out_t graded_next;

  assign adv2        = !v2 || graded_ready;
  assign adv1        = !v1 || adv2;
  assign adv0        = !v0 || adv1;
  assign pixel_ready = adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv0) v0 <= pixel_valid;
      if (adv1) v1 <= v0;
      if (adv2) v2 <= v1;
    end
  end

  // stage 0: offsets
  always_ff @(posedge clk) begin
    if (adv0) begin
      if (cfg.color_control_enable) begin
        r0 <= lcg_pkg::add_clamp(pixel.red_in, cfg.red_offset);
        g0 <= lcg_pkg::add_clamp(pixel.green_in, cfg.green_offset);
        b0 <= lcg_pkg::add_clamp(pixel.blue_in, cfg.blue_offset);
      end else begin
        r0 <= pixel.red_in;
        g0 <= pixel.green_in;
        b0 <= pixel.blue_in;
      end
    end
  end

  // stage 1: luma = floor((sum + 1) / 3) by reciprocal multiply
  assign sum_plus = 10'(r0) + 10'(g0) + 10'(b0) + 10'd1;
  assign prod     = 20'(sum_plus) * 20'(lcg_pkg::DIV3_RECIP);

  always_ff @(posedge clk) begin
    if (adv1) begin
      r1    <= r0;
      g1    <= g0;
      b1    <= b0;
      luma1 <= prod[lcg_pkg::DIV3_SHIFT +: 8];
    end
  end

  // stage 2: blank and limit
  assign blank  = cfg.compression_enable && (luma1 < cfg.luma_threshold);
  assign over   = cfg.compression_enable && (luma1 > cfg.luma_limit);
  assign excess = luma1 - cfg.luma_limit;
  assign r_blk  = blank ? 8'd0 : r1;
  assign g_blk  = blank ? 8'd0 : g1;
  assign b_blk  = blank ? 8'd0 : b1;

  always_comb begin
    if (over) begin
      graded_next.red_out   = lcg_pkg::sub_floor(r_blk, excess);
      graded_next.green_out = lcg_pkg::sub_floor(g_blk, excess);
      graded_next.blue_out  = lcg_pkg::sub_floor(b_blk, excess);
    end else begin
      graded_next.red_out   = r_blk;
      graded_next.green_out = g_blk;
      graded_next.blue_out  = b_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      graded <= graded_next;
    end
  end

  assign graded_valid       = v2;
  assign status.stage_valid = {v2, v1, v0};

endmodule

>>> rtl/led_color_grading_unit.sv
// Top level of the LED color grading unit: register file and grading pipeline
//
// Usage: colors enter on the pixel channel (pixel_valid/pixel_ready, struct
// pixel) and graded colors leave on the graded channel (graded_valid/
// graded_ready, struct graded). A transfer happens when valid and ready are
// both high at a rising clock edge.
// Timing: an accepted color passes through the stage 0, 1 and 2 registers,
// and graded_valid is the valid bit of stage 2. One color
// is accepted every cycle while the receiver keeps up; the pipeline has three stages (offset clamp,
// luma multiply, blank/limit), each stage one register deep.
// When the receiver stalls, each stage holds its color and the pipeline
// keeps filling until all three stages are full; then pixel_ready drops.
// Nothing is dropped or repeated.
// Configuration registers live on an APB port: register i at byte address
// 4*i, written at the access cycle, pready always high. Write only while the
// pipeline is empty. Reset (rst, synchronous) empties the pipeline, clears
// both enables, offsets and threshold, and sets luma_limit to 255.
`include "led_color_grading_unit_macros.svh"

module led_color_grading_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcg_pkg::ADDR_W-1:0]  paddr,
  input  logic [lcg_pkg::DATA_W-1:0]  pwdata,
  output logic [lcg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  lcg_pkg::pixel_in_t          pixel,
  output logic                        graded_valid,
  input  logic                        graded_ready,
  output lcg_pkg::pixel_out_t         graded
);

  lcg_pkg::cfg_t         cfg;
  lcg_pkg::pipe_status_t status;
  lcg_pkg::reg_idx_t     reg_sel;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_sel = lcg_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_control_enable <= 1'b0;
      cfg.compression_enable   <= 1'b0;
      cfg.red_offset           <= '0;
      cfg.green_offset         <= '0;
      cfg.blue_offset          <= '0;
      cfg.luma_threshold       <= '0;
      cfg.luma_limit           <= lcg_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        lcg_pkg::REG_COLOR_CTRL_EN: cfg.color_control_enable <= pwdata[0];
        lcg_pkg::REG_COMPRESS_EN:   cfg.compression_enable   <= pwdata[0];
        lcg_pkg::REG_RED_OFFSET:    cfg.red_offset           <= pwdata[8:0];
        lcg_pkg::REG_GREEN_OFFSET:  cfg.green_offset         <= pwdata[8:0];
        lcg_pkg::REG_BLUE_OFFSET:   cfg.blue_offset          <= pwdata[8:0];
        lcg_pkg::REG_LUMA_THRESH:   cfg.luma_threshold       <= pwdata[7:0];
        lcg_pkg::REG_LUMA_LIMIT:    cfg.luma_limit           <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lcg_pkg::REG_COLOR_CTRL_EN: prdata = 32'(cfg.color_control_enable);
      lcg_pkg::REG_COMPRESS_EN:   prdata = 32'(cfg.compression_enable);
      lcg_pkg::REG_RED_OFFSET:    prdata = 32'(cfg.red_offset);
      lcg_pkg::REG_GREEN_OFFSET:  prdata = 32'(cfg.green_offset);
      lcg_pkg::REG_BLUE_OFFSET:   prdata = 32'(cfg.blue_offset);
      lcg_pkg::REG_LUMA_THRESH:   prdata = 32'(cfg.luma_threshold);
      lcg_pkg::REG_LUMA_LIMIT:    prdata = 32'(cfg.luma_limit);
      default:                    prdata = '0;
    endcase
  end

  lcg_grade_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .graded_valid (graded_valid),
    .graded_ready (graded_ready),
    .graded       (graded),
    .status       (status)
  );

  `LCG_ASSERT_NOW(a_ready_only_when_full, clk, rst, !pixel_ready, &status.stage_valid, "stage free")
  `LCG_ASSERT_NEXT(a_accept_fills_stage0, clk, rst, pixel_valid && pixel_ready, status.stage_valid[0], "not captured")
  `LCG_ASSERT_NEXT(a_stall_holds_last, clk, rst, graded_valid && !graded_ready, status.stage_valid[lcg_pkg::NUM_STAGES-1], "lost")

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the LED color grading unit: offsets, blanking, limiting
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNUSED_REG   = 7;
  localparam int DRAIN_CYCLES = 6;
  localparam int SEGMENTS     = 12;
  localparam int SEG_COLORS   = 50;

  typedef struct {
    bit                  is_write;
    int                  reg_i;
    logic [31:0]         wval;
    lcg_pkg::pixel_in_t  color;
    bit                  fixed;
    lcg_pkg::pixel_out_t want;
  } plan_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [lcg_pkg::ADDR_W-1:0]  paddr = '0;
  logic [lcg_pkg::DATA_W-1:0]  pwdata = '0;
  logic [lcg_pkg::DATA_W-1:0]  prdata;
  logic                        pready;
  logic                        pixel_valid = 1'b0;
  logic                        pixel_ready;
  lcg_pkg::pixel_in_t          pixel = '0;
  logic                        graded_valid;
  logic                        graded_ready = 1'b0;
  lcg_pkg::pixel_out_t         graded;

  lcg_pkg::cfg_t        grade_cfg;
  lcg_pkg::pixel_out_t  expected_grades[$];
  plan_row_t            grading_plan[$];
  int                   tx_idle_pct = 21;
  int                   rx_idle_pct = 69;
  int                   mismatches = 0;
  int                   colors_sent = 0;
  int                   colors_checked = 0;
  int                   settings_used = 0;

  led_color_grading_unit u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
    .graded_valid(graded_valid), .graded_ready(graded_ready), .graded(graded)
  );

  always #1 clk = ~clk;

  function automatic int clamp_chan(int v);
    if (v > 255) return 255;
    if (v < 0) return 0;
    return v;
  endfunction

  function automatic lcg_pkg::pixel_out_t grade_color(lcg_pkg::pixel_in_t c);
    int r, g, b, luma, excess;
    r = c.red_in;
    g = c.green_in;
    b = c.blue_in;
    if (grade_cfg.color_control_enable) begin
      r = clamp_chan(r + int'($signed(grade_cfg.red_offset)));
      g = clamp_chan(g + int'($signed(grade_cfg.green_offset)));
      b = clamp_chan(b + int'($signed(grade_cfg.blue_offset)));
    end
    if (grade_cfg.compression_enable) begin
      luma = (r + g + b + 1) / 3;
      if (luma < int'(grade_cfg.luma_threshold)) begin
        r = 0;
        g = 0;
        b = 0;
      end
      if (luma > int'(grade_cfg.luma_limit)) begin
        excess = luma - int'(grade_cfg.luma_limit);
        r = clamp_chan(r - excess);
        g = clamp_chan(g - excess);
        b = clamp_chan(b - excess);
      end
    end
    return '{red_out: 8'(r), green_out: 8'(g), blue_out: 8'(b)};
  endfunction

  task automatic reset_shadow();
    grade_cfg = '0;
    grade_cfg.luma_limit = 8'd255;
  endtask

  task automatic add_write(int idx, logic [31:0] value);
    plan_row_t row;
    row = '{1'b1, idx, value, '0, 1'b0, '0};
    grading_plan = {grading_plan, row};
  endtask

  task automatic add_color(lcg_pkg::pixel_in_t c, bit fixed, lcg_pkg::pixel_out_t want);
    plan_row_t row;
    row = '{1'b0, 0, 32'd0, c, fixed, want};
    grading_plan = {grading_plan, row};
  endtask

  // Called right after a rising edge; returns right after one.
  task automatic reg_write(int idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= lcg_pkg::ADDR_W'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      lcg_pkg::REG_COLOR_CTRL_EN: grade_cfg.color_control_enable = value[0];
      lcg_pkg::REG_COMPRESS_EN:   grade_cfg.compression_enable = value[0];
      lcg_pkg::REG_RED_OFFSET:    grade_cfg.red_offset = value[8:0];
      lcg_pkg::REG_GREEN_OFFSET:  grade_cfg.green_offset = value[8:0];
      lcg_pkg::REG_BLUE_OFFSET:   grade_cfg.blue_offset = value[8:0];
      lcg_pkg::REG_LUMA_THRESH:   grade_cfg.luma_threshold = value[7:0];
      lcg_pkg::REG_LUMA_LIMIT:    grade_cfg.luma_limit = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_color(lcg_pkg::pixel_in_t c, bit fixed, lcg_pkg::pixel_out_t want);
    lcg_pkg::pixel_out_t exp_grade;
    while ($urandom_range(99) < tx_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= c;
    do @(posedge clk); while (!pixel_ready);
    exp_grade = fixed ? want : grade_color(c);
    expected_grades = {expected_grades, exp_grade};
    colors_sent++;
  endtask

  task automatic wait_drained();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (expected_grades.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(5))
      0: return 32'h0FF;
      1: return 32'h101;
      2: return 32'h100;
      3: return 32'h000;
      default: return {23'd0, 9'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] pick_level();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return 32'd255;
      default: return {24'd0, 8'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    graded_ready <= rst ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    lcg_pkg::pixel_out_t want;
    if (!rst && graded_valid && graded_ready) begin
      if (expected_grades.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected graded color %02h %02h %02h",
                   graded.red_out, graded.green_out, graded.blue_out);
      end else begin
        want = expected_grades.pop_front();
        colors_checked++;
        if (graded.red_out !== want.red_out || graded.green_out !== want.green_out ||
            graded.blue_out !== want.blue_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on graded color %0d: expected %02h %02h %02h, got %02h %02h %02h",
                     colors_checked, want.red_out, want.green_out, want.blue_out,
                     graded.red_out, graded.green_out, graded.blue_out);
        end
      end
    end
  end

  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    lcg_pkg::pixel_in_t c;
    reset_shadow();

    add_color(24'h000000, 1'b1, 24'h000000);
    add_color(24'hFFFFFF, 1'b1, 24'hFFFFFF);
    add_color(24'h123456, 1'b1, 24'h123456);
    add_write(lcg_pkg::REG_COLOR_CTRL_EN, 32'd1);
    add_write(lcg_pkg::REG_RED_OFFSET, 32'h0FF);
    add_write(lcg_pkg::REG_GREEN_OFFSET, 32'h101);
    add_write(lcg_pkg::REG_BLUE_OFFSET, 32'h100);
    add_color(24'h000000, 1'b1, 24'hFF0000);
    add_color(24'hFFFFFF, 1'b1, 24'hFF0000);
    add_color(24'h80FF01, 1'b1, 24'hFF0000);
    add_write(lcg_pkg::REG_RED_OFFSET, 32'h001);
    add_write(lcg_pkg::REG_GREEN_OFFSET, 32'h1FF);
    add_write(lcg_pkg::REG_BLUE_OFFSET, 32'h000);
    add_color(24'hFF007F, 1'b1, 24'hFF007F);
    add_color(24'hFE0100, 1'b1, 24'hFF0000);
    add_write(UNUSED_REG, 32'hFFFFFFFF);
    add_color(24'h405060, 1'b0, '0);
    add_write(lcg_pkg::REG_COLOR_CTRL_EN, 32'd0);
    add_write(lcg_pkg::REG_COMPRESS_EN, 32'd1);
    add_write(lcg_pkg::REG_LUMA_THRESH, 32'd100);
    add_color(24'h000000, 1'b1, 24'h000000);
    add_color(24'h636464, 1'b0, '0);
    add_color(24'h636364, 1'b1, 24'h000000);
    add_write(lcg_pkg::REG_LUMA_THRESH, 32'd0);
    add_write(lcg_pkg::REG_LUMA_LIMIT, 32'd0);
    add_color(24'hFFFFFF, 1'b1, 24'h000000);
    add_color(24'h000000, 1'b1, 24'h000000);
    add_color(24'h010000, 1'b0, '0);
    add_color(24'h010100, 1'b0, '0);
    add_write(lcg_pkg::REG_LUMA_THRESH, 32'd255);
    add_color(24'hFFFFFF, 1'b0, '0);
    add_color(24'h808080, 1'b1, 24'h000000);
    add_write(lcg_pkg::REG_LUMA_THRESH, 32'd0);
    add_write(lcg_pkg::REG_LUMA_LIMIT, 32'd255);
    add_write(lcg_pkg::REG_COLOR_CTRL_EN, 32'd1);
    add_color(24'hFFFFFF, 1'b0, '0);
    add_write(lcg_pkg::REG_LUMA_LIMIT, 32'd200);
    add_color(24'hC8C8C8, 1'b0, '0);
    add_color(24'hD0D0D0, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    settings_used = 1;
    foreach (grading_plan[i]) begin
      if (grading_plan[i].is_write) begin
        if (i == 0 || !grading_plan[i-1].is_write) begin
          wait_drained();
          settings_used++;
        end
        reg_write(grading_plan[i].reg_i, grading_plan[i].wval);
      end else begin
        send_color(grading_plan[i].color, grading_plan[i].fixed, grading_plan[i].want);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 4)
        0: begin tx_idle_pct = 21; rx_idle_pct = 69; end
        1: begin tx_idle_pct = 69; rx_idle_pct = 21; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      wait_drained();
      reg_write(lcg_pkg::REG_COLOR_CTRL_EN, {31'd0, 1'($urandom)});
      reg_write(lcg_pkg::REG_COMPRESS_EN, {31'd0, 1'($urandom)});
      reg_write(lcg_pkg::REG_RED_OFFSET, pick_offset());
      reg_write(lcg_pkg::REG_GREEN_OFFSET, pick_offset());
      reg_write(lcg_pkg::REG_BLUE_OFFSET, pick_offset());
      reg_write(lcg_pkg::REG_LUMA_THRESH, pick_level());
      reg_write(lcg_pkg::REG_LUMA_LIMIT, pick_level());
      settings_used++;
      for (int n = 0; n < SEG_COLORS; n++) begin
        c = '{red_in: pick_chan(), green_in: pick_chan(), blue_in: pick_chan()};
        send_color(c, 1'b0, '0);
      end
    end

    wait_drained();
    $display("Graded %0d colors under %0d register settings, %0d results checked,",
             colors_sent, settings_used, colors_checked);
    $display("with stalls on the input side, the output side, and neither.");
    if (mismatches == 0 && expected_grades.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
